@@ rtl/krd_pkg.sv @@
// Package: shared constants, types and codes of the KISS receive deframer.
`timescale 1ns / 1ps
package krd_pkg;

  // Number of serial links served; link numbers at or above it are ignored.
  localparam int unsigned LINKS = 2;
  localparam int unsigned LinkAw = (LINKS > 1) ? $clog2(LINKS) : 1;

  localparam int unsigned LinkW  = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 10;
  localparam int unsigned IdW    = 16;
  localparam int unsigned EvW    = 3;
  localparam int unsigned PortW  = 8;

  localparam logic [ByteW-1:0] ChFend  = 8'hC0;
  localparam logic [ByteW-1:0] ChFesc  = 8'hDB;
  localparam logic [ByteW-1:0] ChTfend = 8'hDC;
  localparam logic [ByteW-1:0] ChTfesc = 8'hDD;

  localparam logic [3:0] CmdData    = 4'd0;
  localparam logic [3:0] CmdAckmode = 4'd12;

  localparam logic [LenW-1:0] LimitReset = 10'd318;

  localparam logic [EvW-1:0] EvPayload  = 3'd0;
  localparam logic [EvW-1:0] EvDataEnd  = 3'd1;
  localparam logic [EvW-1:0] EvAckEnd   = 3'd2;
  localparam logic [EvW-1:0] EvUnderrun = 3'd3;
  localparam logic [EvW-1:0] EvUnknown  = 3'd4;
  localparam logic [EvW-1:0] EvOverrun  = 3'd5;
  localparam logic [EvW-1:0] EvBadEsc   = 3'd6;

  // Per-link deframing state, one-hot.
  typedef enum logic [2:0] {
    MODE_WAIT = 3'b001,
    MODE_DATA = 3'b010,
    MODE_ESC  = 3'b100
  } mode_e;

  // One entry of the per-link state memory.
  typedef struct packed {
    mode_e            mode;
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] cmd;
    logic [IdW-1:0]   id;
  } link_st_t;

  localparam int unsigned StW = $bits(link_st_t);

  localparam link_st_t StReset = '{
    mode: MODE_WAIT,
    len:  '0,
    cmd:  '0,
    id:   '0
  };

  // One result beat.
  typedef struct packed {
    logic [EvW-1:0]   event_res;
    logic [PortW-1:0] port;
    logic [IdW-1:0]   ack_id;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  count;
  } ev_t;

endpackage

@@ rtl/krd_byte_if.sv @@
// Interface: received byte channel (link number and raw byte).
`timescale 1ns / 1ps
interface krd_byte_if;
  logic       valid;
  logic       ready;
  logic [3:0] link;
  logic [7:0] rx_byte;

  modport source (output valid, output link, output rx_byte, input ready);
  modport sink (input valid, input link, input rx_byte, output ready);
endinterface

@@ rtl/krd_event_if.sv @@
// Interface: deframer event channel.
`timescale 1ns / 1ps
interface krd_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  port;
  logic [15:0] ack_id;
  logic [7:0]  payload_byte;
  logic [9:0]  count;

  modport source (
    output valid, output event_res, output port, output ack_id,
    output payload_byte, output count, input ready
  );
  modport sink (
    input valid, input event_res, input port, input ack_id,
    input payload_byte, input count, output ready
  );
endinterface

@@ rtl/krd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module krd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/kiss_rx_deframer_top.sv @@
// Top level: KISS receive deframer, per-link state held in a RAM.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  rx_i     | in  | valid/ready   | link[3:0], rx_byte[7:0]
//  ev_o     | out | valid/ready   | event_res, port, ack_id, payload_byte, count
//  cfg      | in  | cfg_we_i      | cfg_wdata_i[9:0] = frame_limit
//
// One beat per cycle sustained unless stalled. A beat passes the read stage (state RAM
// read), then the update stage (decode, write back, load the event register).
// Back-to-back beats on the same link see the previous write through a forward register.
// Reset marks every link entry as unwritten; an unwritten entry reads as the idle state.
// A result that waits in the event register stalls the update stage only when that
// stage also holds a result; beats that give no result keep flowing.
`timescale 1ns / 1ps
module kiss_rx_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  krd_byte_if.sink    rx_i,
  krd_event_if.source ev_o,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i
);
  import krd_pkg::*;

  // Configuration register.
  logic [LenW-1:0] limit_q;

  // Update stage.
  logic             s1_valid_q;
  logic [LinkW-1:0] s1_link_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_hit_q;
  link_st_t         fwd_q;

  // Entry written since reset, one bit per link.
  logic [LINKS-1:0] written_q;

  // Event output register.
  logic ev_valid_q;
  ev_t  ev_q;

  logic [StW-1:0]    ram_rdata;
  logic [LinkAw-1:0] s1_addr;
  logic              s1_in_range;
  logic              s1_go;
  logic              accept;
  link_st_t          st;
  link_st_t          st_n;
  ev_t               res;
  logic              res_v;
  logic              take;
  logic [ByteW-1:0]  tb;
  logic [LenW:0]     pos_inc;
  logic [PortW-1:0]  port_unit;
  logic [PortW-1:0]  port_link;

  assign s1_addr     = s1_link_q[LinkAw-1:0];
  assign s1_in_range = ({1'b0, s1_link_q} < (LinkW + 1)'(LINKS));

  // Current state: forwarded write, stored entry, or the reset value.
  always_comb begin
    if (s1_hit_q) begin
      st = fwd_q;
    end else if (written_q[s1_addr]) begin
      st = link_st_t'(ram_rdata);
    end else begin
      st = StReset;
    end
  end

  assign port_link = {s1_link_q, 4'd0};
  assign port_unit = {s1_link_q, st.cmd[7:4]};
  assign pos_inc   = {1'b0, st.len} + (LenW + 1)'(1);

  // Deframer step for the beat in the update stage.
  always_comb begin
    st_n  = st;
    res   = '0;
    res_v = 1'b0;
    take  = 1'b0;
    tb    = s1_byte_q;

    unique case (st.mode)
      MODE_DATA: begin
        if (s1_byte_q == ChFend) begin
          // Close the frame and stay in data mode for the next one.
          st_n.mode = MODE_DATA;
          st_n.len  = '0;
          if (st.len != '0) begin
            res_v    = 1'b1;
            res.port = port_unit;
            if (st.cmd[3:0] == CmdData) begin
              res.event_res = EvDataEnd;
              res.count     = st.len - LenW'(1);
            end else if (st.cmd[3:0] == CmdAckmode) begin
              if (st.len < LenW'(3)) begin
                res.event_res = EvUnderrun;
              end else begin
                res.event_res = EvAckEnd;
                res.ack_id    = st.id;
                res.count     = st.len - LenW'(3);
              end
            end else begin
              res.event_res = EvUnknown;
            end
          end
        end else if (s1_byte_q == ChFesc) begin
          st_n.mode = MODE_ESC;
        end else begin
          take = 1'b1;
        end
      end
      MODE_ESC: begin
        if (s1_byte_q == ChTfend) begin
          take = 1'b1;
          tb   = ChFend;
        end else if (s1_byte_q == ChTfesc) begin
          take = 1'b1;
          tb   = ChFesc;
        end else begin
          st_n.mode     = MODE_DATA;
          res_v         = 1'b1;
          res.event_res = EvBadEsc;
          res.port      = port_link;
        end
      end
      default: begin
        // Waiting: only FEND opens a frame.
        if (s1_byte_q == ChFend) begin
          st_n.mode = MODE_DATA;
          st_n.len  = '0;
        end
      end
    endcase

    if (take) begin
      st_n.len = pos_inc[LenW-1:0];
      if (pos_inc >= {1'b0, limit_q}) begin
        // Overrun: drop the frame and wait for the next start.
        st_n.mode     = MODE_WAIT;
        res_v         = 1'b1;
        res.event_res = EvOverrun;
        res.port      = port_link;
      end else begin
        st_n.mode = MODE_DATA;
        if (st.len == '0) begin
          st_n.cmd = tb;
        end else if (st.cmd[3:0] == CmdData) begin
          res_v            = 1'b1;
          res.event_res    = EvPayload;
          res.port         = port_unit;
          res.payload_byte = tb;
          res.count        = st.len - LenW'(1);
        end else if (st.cmd[3:0] == CmdAckmode) begin
          if (st.len == LenW'(1)) begin
            st_n.id[15:8] = tb;
          end else if (st.len == LenW'(2)) begin
            st_n.id[7:0] = tb;
          end else begin
            res_v            = 1'b1;
            res.event_res    = EvPayload;
            res.port         = port_unit;
            res.ack_id       = st.id;
            res.payload_byte = tb;
            res.count        = st.len - LenW'(3);
          end
        end
      end
    end

    // Ignored links neither change state nor report.
    if (!s1_in_range) begin
      res_v = 1'b0;
    end
  end

  // Advance the update stage unless its result finds the event register full.
  assign s1_go      = !s1_valid_q || !res_v || !ev_valid_q || ev_o.ready;
  assign rx_i.ready = s1_go;
  assign accept     = rx_i.valid && s1_go;

  krd_ram #(
    .WIDTH (StW),
    .DEPTH (LINKS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && s1_go && s1_in_range),
    .waddr_i (s1_addr),
    .wdata_i (st_n),
    .re_i    (accept),
    .raddr_i (rx_i.link[LinkAw-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= LimitReset;
      s1_valid_q <= 1'b0;
      s1_hit_q   <= 1'b0;
      written_q  <= '0;
      ev_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (s1_go) begin
        s1_valid_q <= accept;
        // Forward when the new beat reads the entry written at this edge.
        s1_hit_q   <= accept && s1_valid_q && s1_in_range && (s1_link_q == rx_i.link);
      end
      if (s1_valid_q && s1_go && s1_in_range) begin
        written_q[s1_addr] <= 1'b1;
      end
      if (s1_valid_q && s1_go && res_v) begin
        ev_valid_q <= 1'b1;
      end else if (ev_o.ready) begin
        ev_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_link_q <= rx_i.link;
      s1_byte_q <= rx_i.rx_byte;
      fwd_q     <= st_n;
    end
    if (s1_valid_q && s1_go && res_v) begin
      ev_q <= res;
    end
  end

  assign ev_o.valid        = ev_valid_q;
  assign ev_o.event_res    = ev_q.event_res;
  assign ev_o.port         = ev_q.port;
  assign ev_o.ack_id       = ev_q.ack_id;
  assign ev_o.payload_byte = ev_q.payload_byte;
  assign ev_o.count        = ev_q.count;

endmodule

@@ rtl/krd_checker.sv @@
// Checker: port-level properties of the deframer, bound to the top level.
`timescale 1ns / 1ps
module krd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        ev_valid_i,
  input logic        ev_ready_i,
  input logic [2:0]  ev_event_res_i,
  input logic [7:0]  ev_port_i,
  input logic [15:0] ev_ack_id_i,
  input logic [7:0]  ev_payload_byte_i,
  input logic [9:0]  ev_count_i
);
  import krd_pkg::*;

  // Hold a stalled event beat.
  a_ev_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && !ev_ready_i |=> ev_valid_i && $stable(ev_event_res_i) && $stable(ev_count_i))
    else $error("event beat dropped or changed while stalled");

  a_link_only_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && (ev_event_res_i == EvOverrun || ev_event_res_i == EvBadEsc)
      |-> ev_port_i[3:0] == 4'd0)
    else $error("overrun or bad escape carries a unit number");

  a_byte_only_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && ev_event_res_i != EvPayload |-> ev_payload_byte_i == '0)
    else $error("payload byte set on a non-payload event");

  a_id_usage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && ev_event_res_i != EvPayload && ev_event_res_i != EvAckEnd
      |-> ev_ack_id_i == '0)
    else $error("ack id set on an event without one");

  a_count_usage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && ev_event_res_i != EvPayload && ev_event_res_i != EvDataEnd &&
      ev_event_res_i != EvAckEnd |-> ev_count_i == '0)
    else $error("count set on a status event");

endmodule

bind kiss_rx_deframer_top krd_checker u_krd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .ev_valid_i        (ev_o.valid),
  .ev_ready_i        (ev_o.ready),
  .ev_event_res_i    (ev_o.event_res),
  .ev_port_i         (ev_o.port),
  .ev_ack_id_i       (ev_o.ack_id),
  .ev_payload_byte_i (ev_o.payload_byte),
  .ev_count_i        (ev_o.count)
);

@@ tb/krd_event_checker.sv @@
// Checker: predicts the deframer events from the accepted bytes and compares them.
`timescale 1ns / 1ps
module krd_event_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  krd_byte_if         rx_i,
  krd_event_if        ev_i,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  output int unsigned mismatch_o,
  output int unsigned pending_o
);
  import krd_pkg::*;

  // Per-link deframing state and the frame limit, as the block should hold them.
  mode_e       mode_q [LINKS];
  int unsigned len_q  [LINKS];
  logic [7:0]  cmd_q  [LINKS];
  logic [15:0] id_q   [LINKS];
  int unsigned limit_q;

  ev_t pending_events[$];

  function automatic void queue_event(logic [2:0] kind, logic [7:0] port, logic [15:0] id,
                                      logic [7:0] data, logic [9:0] cnt);
    ev_t e;
    e.event_res    = kind;
    e.port         = port;
    e.ack_id       = id;
    e.payload_byte = data;
    e.count        = cnt;
    pending_events.push_back(e);
  endfunction

  // Buffer one unescaped byte of the frame on link ln.
  function automatic void store_byte(logic [3:0] ln, logic [7:0] b);
    int unsigned pos;
    logic [7:0]  port;
    pos = len_q[ln];
    len_q[ln] = (pos + 1) % 1024;
    if (pos + 1 >= limit_q) begin
      mode_q[ln] = MODE_WAIT;
      queue_event(EvOverrun, {ln, 4'h0}, '0, '0, '0);
      return;
    end
    mode_q[ln] = MODE_DATA;
    if (pos == 0) begin
      cmd_q[ln] = b;
      return;
    end
    port = {ln, cmd_q[ln][7:4]};
    if (cmd_q[ln][3:0] == CmdData) begin
      queue_event(EvPayload, port, '0, b, 10'(pos - 1));
    end else if (cmd_q[ln][3:0] == CmdAckmode) begin
      if (pos == 1) id_q[ln][15:8] = b;
      else if (pos == 2) id_q[ln][7:0] = b;
      else queue_event(EvPayload, port, id_q[ln], b, 10'(pos - 3));
    end
  endfunction

  function automatic void deframe_byte(logic [3:0] ln, logic [7:0] b);
    int unsigned len;
    logic [7:0]  port;
    if (ln >= LINKS) return;
    case (mode_q[ln])
      MODE_DATA: begin
        if (b == ChFend) begin
          // closing FEND: report the frame, clear the length, stay in data mode
          len = len_q[ln];
          port = {ln, cmd_q[ln][7:4]};
          len_q[ln] = 0;
          if (len != 0) begin
            if (cmd_q[ln][3:0] == CmdData) begin
              queue_event(EvDataEnd, port, '0, '0, 10'(len - 1));
            end else if (cmd_q[ln][3:0] == CmdAckmode) begin
              if (len < 3) queue_event(EvUnderrun, port, '0, '0, '0);
              else queue_event(EvAckEnd, port, id_q[ln], '0, 10'(len - 3));
            end else begin
              queue_event(EvUnknown, port, '0, '0, '0);
            end
          end
        end else if (b == ChFesc) begin
          mode_q[ln] = MODE_ESC;
        end else begin
          store_byte(ln, b);
        end
      end
      MODE_ESC: begin
        if (b == ChTfend) store_byte(ln, ChFend);
        else if (b == ChTfesc) store_byte(ln, ChFesc);
        else begin
          mode_q[ln] = MODE_DATA;
          queue_event(EvBadEsc, {ln, 4'h0}, '0, '0, '0);
        end
      end
      default: begin
        if (b == ChFend) begin
          mode_q[ln] = MODE_DATA;
          len_q[ln] = 0;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_o++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ev_t got;
    ev_t want;
    if (!rst_ni) begin
      for (int i = 0; i < LINKS; i++) begin
        mode_q[i] = MODE_WAIT;
        len_q[i]  = 0;
        cmd_q[i]  = '0;
        id_q[i]   = '0;
      end
      limit_q = LimitReset;
      pending_events.delete();
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (rx_i.valid && rx_i.ready) deframe_byte(rx_i.link, rx_i.rx_byte);
      if (ev_i.valid && ev_i.ready) begin
        got.event_res    = ev_i.event_res;
        got.port         = ev_i.port;
        got.ack_id       = ev_i.ack_id;
        got.payload_byte = ev_i.payload_byte;
        got.count        = ev_i.count;
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("event %0d port %h with nothing pending",
                                    got.event_res, got.port));
        end else begin
          want = pending_events.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              "got ev %0d port %h id %h byte %h cnt %0d, want ev %0d port %h id %h byte %h cnt %0d",
              got.event_res, got.port, got.ack_id, got.payload_byte, got.count,
              want.event_res, want.port, want.ack_id, want.payload_byte, want.count));
          end
        end
      end
    end
    pending_o = pending_events.size();
  end

endmodule

@@ tb/testbench.sv @@
// Testbench top: drives received bytes, throttles events, writes the frame limit, gives the verdict.
`timescale 1ns / 1ps
module testbench;
  import krd_pkg::*;

  // Longest run of cycles with no beat on either channel; the receiver hold-off is
  // the longest legal one, so leave plenty of room above it.
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 400;
  localparam int Chunks     = 4;
  localparam int ChunkBeats = 100;

  typedef logic [7:0] bytes_t[$];
  typedef struct packed {
    logic [3:0] link;
    logic [7:0] data;
  } beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [9:0] cfg_wdata;

  krd_byte_if  rx_bus ();
  krd_event_if ev_bus ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned idle_cycles = 0;

  // Beats waiting to be offered, in order.
  beat_t tx_beats[$];

  // Idle knobs: the quiet flags turn off random gaps for a stretch; hold_req asks the
  // receiver for one long hold-off.
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  kiss_rx_deframer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_bus),
    .ev_o        (ev_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  krd_event_checker event_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_bus),
    .ev_i        (ev_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .mismatch_o  (mismatches),
    .pending_o   (pending)
  );

  // Watchdog: end the run when neither channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if ((rx_bus.valid && rx_bus.ready) || (ev_bus.valid && ev_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Bias toward the framing characters and the byte extremes.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return ChFend;
      1:       return ChFesc;
      2:       return ChTfend;
      3:       return ChTfesc;
      4:       return 8'h00;
      5:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void put(logic [3:0] ln, logic [7:0] b);
    beat_t bt;
    bt.link = ln;
    bt.data = b;
    tx_beats.push_back(bt);
  endfunction

  // Wrap a frame body in FENDs and escape it; optionally slip in one broken escape
  // (FESC followed by anything but TFEND or TFESC, FEND included).
  function automatic bytes_t framed(bytes_t body, bit with_bad_esc);
    bytes_t     q;
    int         cut;
    logic [7:0] bad_b;
    cut = with_bad_esc ? int'($urandom_range(0, body.size())) : -1;
    bad_b = ($urandom_range(0, 2) == 0) ? ChFend : 8'($urandom);
    if (bad_b == ChTfend || bad_b == ChTfesc) bad_b = ChFesc;
    q.push_back(ChFend);
    for (int i = 0; i <= body.size(); i++) begin
      if (i == cut) begin
        q.push_back(ChFesc);
        q.push_back(bad_b);
      end
      if (i < body.size()) begin
        if (body[i] == ChFend) begin
          q.push_back(ChFesc);
          q.push_back(ChTfend);
        end else if (body[i] == ChFesc) begin
          q.push_back(ChFesc);
          q.push_back(ChTfesc);
        end else begin
          q.push_back(body[i]);
        end
      end
    end
    q.push_back(ChFend);
    return q;
  endfunction

  // Mostly data and ackmode frames, some other commands, empty and short frames.
  function automatic bytes_t random_body();
    bytes_t     q;
    int         kind;
    int         n;
    int         keep;
    logic [3:0] op;
    kind = $urandom_range(0, 9);
    if (kind < 5) op = CmdData;
    else if (kind < 8) op = CmdAckmode;
    else begin
      op = 4'($urandom_range(1, 15));
      if (op == CmdAckmode) op = 4'd5;
    end
    if ($urandom_range(0, 15) == 0) return q;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    q.push_back({4'($urandom), op});
    if (op == CmdAckmode) begin
      q.push_back(rand_byte());
      q.push_back(rand_byte());
    end
    repeat (n) q.push_back(rand_byte());
    // cut an ackmode frame short of its id now and then
    if (op == CmdAckmode && $urandom_range(0, 4) == 0) begin
      keep = $urandom_range(1, 2);
      while (q.size() > keep) void'(q.pop_back());
    end
    return q;
  endfunction

  function automatic void add_data_frame(logic [3:0] ln, logic [7:0] cmd, int n);
    bytes_t body;
    bytes_t bq;
    body.push_back(cmd);
    repeat (n) body.push_back(rand_byte());
    bq = framed(body, 1'b0);
    foreach (bq[i]) put(ln, bq[i]);
  endfunction

  // Build one stretch of traffic: frames on both links interleaved byte by byte,
  // with stray bytes and bytes on links the block ignores mixed in.
  function automatic void build_chunk(int target);
    bytes_t lane0;
    bytes_t lane1;
    beat_t  noise_q[$];
    beat_t  bt;
    int     pick;
    while (lane0.size() + lane1.size() + noise_q.size() < target) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        bt.link = 4'($urandom_range(LINKS, 15));
        bt.data = rand_byte();
        noise_q.push_back(bt);
      end else if (pick == 1) begin
        lane0.push_back(rand_byte());
      end else if (pick == 2) begin
        lane1.push_back(rand_byte());
      end else if (pick % 2 == 1) begin
        lane1 = {lane1, framed(random_body(), $urandom_range(0, 9) == 0)};
      end else begin
        lane0 = {lane0, framed(random_body(), $urandom_range(0, 9) == 0)};
      end
    end
    while (lane0.size() + lane1.size() + noise_q.size() > 0) begin
      pick = $urandom_range(0, 2);
      if (pick == 0 && lane0.size() > 0) put(4'd0, lane0.pop_front());
      else if (pick == 1 && lane1.size() > 0) put(4'd1, lane1.pop_front());
      else if (pick == 2 && noise_q.size() > 0) tx_beats.push_back(noise_q.pop_front());
    end
  endfunction

  // Offer every queued beat. Valid stays high across back-to-back beats and drops
  // only for a gap or after the last beat, so it gets one update per edge at most.
  task automatic drive_beats();
    beat_t bt;
    int    gap;
    while (tx_beats.size() > 0) begin
      bt = tx_beats.pop_front();
      gap = tx_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        rx_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rx_bus.valid   <= 1'b1;
      rx_bus.link    <= bt.link;
      rx_bus.rx_byte <= bt.data;
      do @(posedge clk_i); while (!rx_bus.ready);
    end
    rx_bus.valid <= 1'b0;
  endtask

  // Wait for every event, let the pipeline empty, then write the frame limit.
  task automatic set_limit(input logic [9:0] value);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Event receiver: hold ready low at random before each beat, or hold off for a
  // long stretch on request so the block backs up into its input.
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        stall = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        ev_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      ev_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!ev_bus.valid);
    end
  end

  initial begin
    logic [9:0] lim;
    rst_ni         = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.link    = '0;
    rx_bus.rx_byte = '0;
    ev_bus.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed traffic at the reset limit.
    // Link 0 is still waiting: drop these without a trace.
    put(4'd0, 8'h41);
    put(4'd0, ChFesc);
    // Open and close an empty frame: nothing comes out.
    put(4'd0, ChFend);
    put(4'd0, ChFend);
    // Data frame, unit 0: payload FF, then both escapes, then the data end.
    put(4'd0, 8'h00);
    put(4'd0, 8'hFF);
    put(4'd0, ChFesc);
    put(4'd0, ChTfend);
    put(4'd0, ChFesc);
    put(4'd0, ChTfesc);
    put(4'd0, ChFend);
    // Ackmode frame on link 1, unit F, id FFFF, one payload byte.
    put(4'd1, ChFend);
    put(4'd1, 8'hFC);
    put(4'd1, 8'hFF);
    put(4'd1, 8'hFF);
    put(4'd1, 8'h5A);
    put(4'd1, ChFend);
    // Ackmode frame holding the command byte alone: underrun.
    put(4'd1, 8'hFC);
    put(4'd1, ChFend);
    // Some other command: payload withheld, unknown command at the close.
    put(4'd0, 8'h35);
    put(4'd0, 8'h77);
    put(4'd0, ChFend);
    // FEND right after FESC is a bad escape, not a close.
    put(4'd0, ChFesc);
    put(4'd0, ChFend);
    // Links past the last one are ignored.
    put(4'hF, ChFend);
    put(4'd2, ChFesc);
    drive_beats();

    // Tiny limit: the fourth buffered byte overruns and drops the link to waiting.
    set_limit(10'd4);
    put(4'd0, 8'h00);
    put(4'd0, 8'h01);
    put(4'd0, 8'h02);
    put(4'd0, 8'h03);
    put(4'd0, ChFend);
    drive_beats();

    // Lowest limit: every buffered byte overruns, escaped ones too.
    set_limit(10'd1);
    put(4'd0, 8'h11);
    put(4'd0, ChFend);
    put(4'd0, ChFesc);
    put(4'd0, ChTfend);
    put(4'd0, ChFend);
    put(4'd0, 8'h22);
    drive_beats();

    // Highest limit: a long frame passes without an overrun.
    set_limit(10'd1023);
    add_data_frame(4'd1, 8'h00, 120);
    drive_beats();

    // Back-pressure: hold the receiver off while link 0 streams a frame at full rate.
    tx_quiet = 1'b1;
    hold_req = 1'b1;
    add_data_frame(4'd0, 8'h10, 150);
    drive_beats();
    tx_quiet = 1'b0;

    // Random traffic, a new limit and new idle pattern for every stretch.
    repeat (Chunks) begin
      case ($urandom_range(0, 3))
        0:       lim = 10'($urandom_range(2, 12));
        1:       lim = 10'($urandom_range(13, 1022));
        2:       lim = LimitReset;
        default: lim = 10'd1023;
      endcase
      set_limit(lim);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      build_chunk(ChunkBeats);
      drive_beats();
    end
    rx_quiet = 1'b0;

    // Drain, then give the pipeline time to show any stray event.
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
